### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

### rtl/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

  localparam int CD_WIDTH_DEFAULT = 16;
  localparam int NUM_COUNTDOWNS   = 11;
  localparam int SEL_WIDTH        = 4;
  localparam int EXP_WIDTH        = 6;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_LOAD = 2'd1,
    ACT_READ = 2'd2
  } tts_action_t;

  localparam logic [3:0] CD_VFO_SAVE   = 4'd0;
  localparam logic [3:0] CD_TX_TIMEOUT = 4'd1;
  localparam logic [3:0] CD_RX_TIMER   = 4'd2;
  localparam logic [3:0] CD_SERIAL_CFG = 4'd3;
  localparam logic [3:0] CD_CDCSS      = 4'd4;
  localparam logic [3:0] CD_CTCSS      = 4'd5;
  localparam logic [3:0] CD_BATT_SAVE  = 4'd6;
  localparam logic [3:0] CD_POWER_SAVE = 4'd7;
  localparam logic [3:0] CD_TAIL_NOTE  = 4'd8;
  localparam logic [3:0] CD_FM_PLAY    = 4'd9;
  localparam logic [3:0] CD_BOOT       = 4'd10;

  localparam logic [2:0] MODE_FOREGROUND = 3'd0;
  localparam logic [2:0] MODE_POWER_SAVE = 3'd1;
  localparam logic [2:0] MODE_MONITOR    = 3'd2;
  localparam logic [2:0] MODE_TRANSMIT   = 3'd3;
  localparam logic [2:0] MODE_RECEIVE    = 3'd4;

  localparam logic [3:0] DIV_150_RELOAD  = 4'd15;
  localparam logic [4:0] DIV_200_RELOAD  = 5'd20;
  localparam logic [5:0] DIV_470_RELOAD  = 6'd47;
  localparam logic [5:0] DIV_500_RELOAD  = 6'd50;
  localparam logic [6:0] DIV_1000_RELOAD = 7'd100;
  localparam logic [8:0] BEACON_RELOAD   = 9'd500;
  localparam logic [8:0] BEACON_OFF_AT   = 9'd470;

  typedef struct packed {
    logic auto_ptt_pulse;
    logic beacon_off;
    logic beacon_on;
    logic slice_1000ms;
    logic slice_500ms;
    logic slice_470ms;
    logic slice_200ms;
    logic slice_150ms;
    logic slice_40ms;
  } tts_slices_t;

  typedef struct packed {
    logic        pad;
    logic [15:0] counter_value;
    logic [5:0]  expired_mask;
    tts_slices_t slices;
    logic [31:0] tick_count;
  } tts_result_t;

endpackage

### rtl/tts_timebase.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tts_timebase
  import tts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata,
  input  logic        tick_en,
  output logic [31:0] tick_count,
  output tts_slices_t slices
);

  logic [31:0] count, count_next;
  logic [3:0]  d150, d150_next;
  logic [4:0]  d200, d200_next;
  logic [5:0]  d470, d470_next;
  logic [5:0]  d500, d500_next;
  logic [6:0]  d1000, d1000_next;
  logic [8:0]  beacon, beacon_next;
  logic [8:0]  beacon_dec;
  logic [15:0] ptt, ptt_next;
  logic [15:0] ptt_inc;
  logic [15:0] secs_ext;
  logic [15:0] ptt_period;
  logic [9:0]  auto_ptt_seconds;

  // period in ticks = seconds * 100, kept to 16 bits
  assign secs_ext   = {6'd0, auto_ptt_seconds};
  assign ptt_period = (secs_ext << 6) + (secs_ext << 5) + (secs_ext << 2);
  assign ptt_inc    = ptt + 16'd1;
  assign beacon_dec = beacon - 9'd1;

  always_comb begin
    count_next  = count;
    d150_next   = d150;
    d200_next   = d200;
    d470_next   = d470;
    d500_next   = d500;
    d1000_next  = d1000;
    beacon_next = beacon;
    ptt_next    = ptt;
    slices      = '0;
    if (tick_en) begin
      count_next = count + 32'd1;
      slices.slice_40ms = (count_next[1:0] == 2'b00);

      if (d150 == 4'd1) begin
        d150_next = DIV_150_RELOAD;
        slices.slice_150ms = 1'b1;
      end else begin
        d150_next = d150 - 4'd1;
      end

      if (d200 == 5'd1) begin
        d200_next = DIV_200_RELOAD;
        slices.slice_200ms = 1'b1;
      end else begin
        d200_next = d200 - 5'd1;
      end

      if (d470 == 6'd1) begin
        d470_next = DIV_470_RELOAD;
        slices.slice_470ms = 1'b1;
      end else begin
        d470_next = d470 - 6'd1;
      end

      if (d500 == 6'd1) begin
        d500_next = DIV_500_RELOAD;
        slices.slice_500ms = 1'b1;
      end else begin
        d500_next = d500 - 6'd1;
      end

      if (d1000 == 7'd1) begin
        d1000_next = DIV_1000_RELOAD;
        slices.slice_1000ms = 1'b1;
      end else begin
        d1000_next = d1000 - 7'd1;
      end

      if (beacon_dec == 9'd0) begin
        beacon_next = BEACON_RELOAD;
        slices.beacon_on = 1'b1;
      end else begin
        beacon_next = beacon_dec;
        slices.beacon_off = (beacon_dec == BEACON_OFF_AT);
      end

      if (auto_ptt_seconds != 10'd0) begin
        if (ptt_inc >= ptt_period) begin
          ptt_next = 16'd0;
          slices.auto_ptt_pulse = 1'b1;
        end else begin
          ptt_next = ptt_inc;
        end
      end
    end
  end

  assign tick_count = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      count            <= 32'd0;
      d150             <= DIV_150_RELOAD;
      d200             <= DIV_200_RELOAD;
      d470             <= DIV_470_RELOAD;
      d500             <= DIV_500_RELOAD;
      d1000            <= DIV_1000_RELOAD;
      beacon           <= BEACON_RELOAD;
      ptt              <= 16'd0;
      auto_ptt_seconds <= 10'd0;
    end else begin
      count  <= count_next;
      d150   <= d150_next;
      d200   <= d200_next;
      d470   <= d470_next;
      d500   <= d500_next;
      d1000  <= d1000_next;
      beacon <= beacon_next;
      ptt    <= ptt_next;
      if (cfg_wen) begin
        auto_ptt_seconds <= cfg_wdata;
      end
    end
  end

  `ASSERT_NEXT(a_tick_advances, clk, rst, tick_en, count == $past(count) + 32'd1)
  `ASSERT_IMPLIES(a_no_pulse_idle, clk, rst, !tick_en, slices == '0)

endmodule

### rtl/tts_countdowns.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tts_countdowns
  import tts_pkg::*;
#(
  parameter int COUNTDOWN_WIDTH = CD_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_en,
  input  logic                 load_en,
  input  logic [SEL_WIDTH-1:0] sel,
  input  logic [15:0]          load_value,
  input  logic [2:0]           radio_mode,
  input  logic                 fm_scan_active,
  input  logic                 slice_500,
  output logic [EXP_WIDTH-1:0] expired_mask,
  output logic [15:0]          read_data
);

  localparam logic [COUNTDOWN_WIDTH-1:0] CD_ONE = COUNTDOWN_WIDTH'(1);

  logic [COUNTDOWN_WIDTH-1:0] cd      [NUM_COUNTDOWNS];
  logic [COUNTDOWN_WIDTH-1:0] cd_next [NUM_COUNTDOWNS];
  logic [NUM_COUNTDOWNS-1:0]  step_en;
  logic [NUM_COUNTDOWNS-1:0]  hit_zero;
  logic [COUNTDOWN_WIDTH-1:0] load_w;
  logic [COUNTDOWN_WIDTH-1:0] sel_value;
  logic                       sel_ok;

  generate
    if (COUNTDOWN_WIDTH > 16) begin : g_wide
      assign load_w    = {{(COUNTDOWN_WIDTH-16){1'b0}}, load_value};
      assign read_data = sel_value[15:0];
    end else if (COUNTDOWN_WIDTH == 16) begin : g_even
      assign load_w    = load_value;
      assign read_data = sel_value;
    end else begin : g_narrow
      assign load_w    = load_value[COUNTDOWN_WIDTH-1:0];
      assign read_data = {{(16-COUNTDOWN_WIDTH){1'b0}}, sel_value};
    end
  endgenerate

  always_comb begin
    step_en                = {NUM_COUNTDOWNS{1'b1}};
    step_en[CD_TX_TIMEOUT] = slice_500;
    step_en[CD_RX_TIMER]   = slice_500;
    step_en[CD_SERIAL_CFG] = slice_500;
    step_en[CD_BATT_SAVE]  = (radio_mode == MODE_FOREGROUND);
    step_en[CD_POWER_SAVE] = (radio_mode == MODE_POWER_SAVE);
    step_en[CD_FM_PLAY]    = fm_scan_active &&
                             !(radio_mode inside {MODE_MONITOR, MODE_TRANSMIT, MODE_RECEIVE});
  end

  always_comb begin
    for (int i = 0; i < NUM_COUNTDOWNS; i++) begin
      cd_next[i]  = cd[i];
      hit_zero[i] = 1'b0;
      if (tick_en && step_en[i] && (cd[i] != '0)) begin
        cd_next[i]  = cd[i] - CD_ONE;
        hit_zero[i] = (cd[i] == CD_ONE);
      end
    end
    if (load_en && (sel < SEL_WIDTH'(NUM_COUNTDOWNS))) begin
      cd_next[sel] = load_w;
    end
  end

  assign expired_mask = {hit_zero[CD_FM_PLAY], hit_zero[CD_TAIL_NOTE],
                         hit_zero[CD_POWER_SAVE], hit_zero[CD_BATT_SAVE],
                         hit_zero[CD_TX_TIMEOUT], hit_zero[CD_VFO_SAVE]};

  assign sel_ok    = (sel < SEL_WIDTH'(NUM_COUNTDOWNS));
  assign sel_value = sel_ok ? cd[sel] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COUNTDOWNS; i++) begin
        cd[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COUNTDOWNS; i++) begin
        cd[i] <= cd_next[i];
      end
    end
  end

  `ASSERT_IMPLIES(a_expiry_only_on_tick, clk, rst, !tick_en, expired_mask == '0)
  `ASSERT_NEXT(a_vfo_save_expires, clk, rst, tick_en && (cd[CD_VFO_SAVE] == CD_ONE), cd[CD_VFO_SAVE] == '0)

endmodule

### rtl/tick_timeslice_scheduler.sv
`timescale 1ns / 1ps

// channel   dir  signals                      transaction
// s         in   s_tvalid/s_tready/s_tdata/    one tick, load or read item
//                s_tuser
// m         out  m_tvalid/m_tready/m_tdata     one result per item
// cfg       in   cfg_wen/cfg_wdata             auto PTT period, seconds
//
// Each item passes through the input register and then the result register;
// one item per cycle sustained while m is not stalled.
// All counters, dividers and the eleven countdowns update in the cycle the
// input register hands its item to the result register.
// rst is synchronous; no clearing pass, the block takes items right after.
// A stall on m holds the result register, then the input register, then s_tready.

`include "assert_macros.svh"

module tick_timeslice_scheduler
  import tts_pkg::*;
#(
  parameter int COUNTDOWN_WIDTH = CD_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // load_value[15:0], radio_mode[18:16], fm_scan_active[19]
  input  logic [5:0]  s_tuser,   // action[1:0], timer_select[5:2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // tick_count[31:0], slice_40ms[32], slice_150ms[33],
                                 // slice_200ms[34], slice_470ms[35], slice_500ms[36],
                                 // slice_1000ms[37], beacon_on[38], beacon_off[39],
                                 // auto_ptt_pulse[40], expired_mask[46:41],
                                 // counter_value[62:47]
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata
);

  logic                 in_valid;
  tts_action_t          in_action;
  logic [SEL_WIDTH-1:0] in_sel;
  logic [15:0]          in_load;
  logic [2:0]           in_mode;
  logic                 in_fm;

  logic                 advance;
  logic                 s_accept;
  logic                 tick_en;
  logic                 load_en;
  logic [31:0]          tick_count;
  tts_slices_t          slices;
  logic [EXP_WIDTH-1:0] expired_mask;
  logic [15:0]          read_data;
  tts_result_t          result;
  tts_result_t          out_data;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    tick_en = 1'b0;
    load_en = 1'b0;
    case (in_action)
      ACT_TICK: tick_en = advance;
      ACT_LOAD: load_en = advance;
      ACT_READ: ;
      default: ;
    endcase
  end

  tts_timebase u_timebase (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .tick_en    (tick_en),
    .tick_count (tick_count),
    .slices     (slices)
  );

  tts_countdowns #(
    .COUNTDOWN_WIDTH (COUNTDOWN_WIDTH)
  ) u_countdowns (
    .clk            (clk),
    .rst            (rst),
    .tick_en        (tick_en),
    .load_en        (load_en),
    .sel            (in_sel),
    .load_value     (in_load),
    .radio_mode     (in_mode),
    .fm_scan_active (in_fm),
    .slice_500      (slices.slice_500ms),
    .expired_mask   (expired_mask),
    .read_data      (read_data)
  );

  always_comb begin
    result               = '0;
    result.tick_count    = tick_count;
    result.slices        = slices;
    result.expired_mask  = expired_mask;
    result.counter_value = (in_action == ACT_READ) ? read_data : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_action <= tts_action_t'(s_tuser[1:0]);
      in_sel    <= s_tuser[5:2];
      in_load   <= s_tdata[15:0];
      in_mode   <= s_tdata[18:16];
      in_fm     <= s_tdata[19];
    end
    if (advance) begin
      out_data <= result;
    end
  end

  assign m_tdata = out_data;

  `ASSERT_IMPLIES(a_no_overrun, clk, rst, in_valid && m_tvalid && !m_tready, !s_tready)
  `ASSERT_IMPLIES(a_single_action, clk, rst, 1'b1, !(tick_en && load_en))

endmodule

### verif/tts_result_checker.sv
`timescale 1ns / 1ps

module tts_result_checker
  import tts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [5:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata,
  output int          mismatches,
  output int          outstanding,
  output int          ticks_seen,
  output int          expiry_ticks
);

  localparam int EXP_VFO_SAVE   = 0;
  localparam int EXP_TX_TIMEOUT = 1;
  localparam int EXP_BATT_SAVE  = 2;
  localparam int EXP_POWER_SAVE = 3;
  localparam int EXP_TAIL_NOTE  = 4;
  localparam int EXP_FM_PLAY    = 5;
  localparam int MAX_REPORTS    = 10;

  logic [31:0] tick_total;
  logic [3:0]  ctr_150;
  logic [4:0]  ctr_200;
  logic [5:0]  ctr_470;
  logic [5:0]  ctr_500;
  logic [6:0]  ctr_1000;
  logic [8:0]  beacon_ctr;
  logic [15:0] ptt_ticks;
  logic [9:0]  ptt_seconds;
  logic [CD_WIDTH_DEFAULT-1:0] timers [NUM_COUNTDOWNS];

  tts_result_t expected_results [$];
  int n_err;
  int n_checked;
  int n_ticks;
  int n_expiry;

  assign mismatches   = n_err;
  assign ticks_seen   = n_ticks;
  assign expiry_ticks = n_expiry;

  function automatic logic count_down(input logic [3:0] idx);
    if (timers[idx] != 0) begin
      timers[idx] = timers[idx] - 1'b1;
      return timers[idx] == 0;
    end
    return 1'b0;
  endfunction

  function automatic tts_result_t schedule_item(input logic [1:0] act, input logic [3:0] sel,
                                                input logic [15:0] load, input logic [2:0] mode,
                                                input logic fm);
    tts_result_t r;
    logic [5:0]  exp;
    logic [31:0] prod;
    logic [15:0] period;
    r = '0;
    exp = '0;
    case (act)
      ACT_TICK: begin
        tick_total = tick_total + 1;
        ctr_200 = ctr_200 - 1'b1;
        if (ctr_200 == 0) begin
          ctr_200 = DIV_200_RELOAD;
          r.slices.slice_200ms = 1'b1;
        end
        ctr_150 = ctr_150 - 1'b1;
        if (ctr_150 == 0) begin
          ctr_150 = DIV_150_RELOAD;
          r.slices.slice_150ms = 1'b1;
        end
        ctr_470 = ctr_470 - 1'b1;
        if (ctr_470 == 0) begin
          ctr_470 = DIV_470_RELOAD;
          r.slices.slice_470ms = 1'b1;
        end
        ctr_1000 = ctr_1000 - 1'b1;
        if (ctr_1000 == 0) begin
          ctr_1000 = DIV_1000_RELOAD;
          r.slices.slice_1000ms = 1'b1;
        end
        beacon_ctr = beacon_ctr - 1'b1;
        if (beacon_ctr == 0) begin
          beacon_ctr = BEACON_RELOAD;
          r.slices.beacon_on = 1'b1;
        end else if (beacon_ctr == BEACON_OFF_AT) begin
          r.slices.beacon_off = 1'b1;
        end
        if (ptt_seconds != 0) begin
          prod = ptt_seconds * 32'd100;
          period = prod[15:0];
          ptt_ticks = ptt_ticks + 1'b1;
          if (ptt_ticks >= period) begin
            ptt_ticks = '0;
            r.slices.auto_ptt_pulse = 1'b1;
          end
        end
        exp[EXP_VFO_SAVE] = count_down(CD_VFO_SAVE);
        ctr_500 = ctr_500 - 1'b1;
        if (ctr_500 == 0) begin
          ctr_500 = DIV_500_RELOAD;
          r.slices.slice_500ms = 1'b1;
          void'(count_down(CD_RX_TIMER));
          exp[EXP_TX_TIMEOUT] = count_down(CD_TX_TIMEOUT);
          void'(count_down(CD_SERIAL_CFG));
        end
        r.slices.slice_40ms = (tick_total[1:0] == 2'd0);
        void'(count_down(CD_CDCSS));
        void'(count_down(CD_CTCSS));
        if (mode == MODE_FOREGROUND) exp[EXP_BATT_SAVE] = count_down(CD_BATT_SAVE);
        if (mode == MODE_POWER_SAVE) exp[EXP_POWER_SAVE] = count_down(CD_POWER_SAVE);
        exp[EXP_TAIL_NOTE] = count_down(CD_TAIL_NOTE);
        if (fm && mode != MODE_MONITOR && mode != MODE_TRANSMIT && mode != MODE_RECEIVE)
          exp[EXP_FM_PLAY] = count_down(CD_FM_PLAY);
        void'(count_down(CD_BOOT));
        r.expired_mask = exp;
        n_ticks++;
        if (exp != 0) n_expiry++;
      end
      ACT_LOAD: begin
        if (sel < NUM_COUNTDOWNS) timers[sel] = load[CD_WIDTH_DEFAULT-1:0];
      end
      ACT_READ: begin
        if (sel < NUM_COUNTDOWNS) r.counter_value = timers[sel];
      end
      default: ;
    endcase
    r.tick_count = tick_total;
    return r;
  endfunction

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      n_err++;
      if (n_err <= MAX_REPORTS)
        $display("mismatch in result %0d, %s: expected %0h, got %0h",
                 n_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tts_result_t want;
    tts_result_t got;
    if (rst) begin
      tick_total  = '0;
      ctr_150     = DIV_150_RELOAD;
      ctr_200     = DIV_200_RELOAD;
      ctr_470     = DIV_470_RELOAD;
      ctr_500     = DIV_500_RELOAD;
      ctr_1000    = DIV_1000_RELOAD;
      beacon_ctr  = BEACON_RELOAD;
      ptt_ticks   = '0;
      ptt_seconds = '0;
      for (int i = 0; i < NUM_COUNTDOWNS; i++) timers[i] = '0;
      expected_results.delete();
      n_err     = 0;
      n_checked = 0;
      n_ticks   = 0;
      n_expiry  = 0;
    end else begin
      if (cfg_wen) ptt_seconds = cfg_wdata;
      if (s_tvalid && s_tready)
        expected_results.push_back(schedule_item(s_tuser[1:0], s_tuser[5:2], s_tdata[15:0],
                                                 s_tdata[18:16], s_tdata[19]));
      if (m_tvalid && m_tready) begin
        got = tts_result_t'(m_tdata);
        if (expected_results.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS)
            $display("unexpected result %0h with nothing pending", m_tdata);
        end else begin
          want = expected_results.pop_front();
          compare_field("tick_count", want.tick_count, got.tick_count);
          compare_field("slice_40ms", want.slices.slice_40ms, got.slices.slice_40ms);
          compare_field("slice_150ms", want.slices.slice_150ms, got.slices.slice_150ms);
          compare_field("slice_200ms", want.slices.slice_200ms, got.slices.slice_200ms);
          compare_field("slice_470ms", want.slices.slice_470ms, got.slices.slice_470ms);
          compare_field("slice_500ms", want.slices.slice_500ms, got.slices.slice_500ms);
          compare_field("slice_1000ms", want.slices.slice_1000ms, got.slices.slice_1000ms);
          compare_field("beacon_on", want.slices.beacon_on, got.slices.beacon_on);
          compare_field("beacon_off", want.slices.beacon_off, got.slices.beacon_off);
          compare_field("auto_ptt_pulse", want.slices.auto_ptt_pulse,
                        got.slices.auto_ptt_pulse);
          compare_field("expired_mask", want.expired_mask, got.expired_mask);
          compare_field("counter_value", want.counter_value, got.counter_value);
          n_checked++;
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tts_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int WATCHDOG_CYCLES  = 5000;
  localparam int SEGMENT_ITEMS    = 206;
  localparam int NUM_SEGMENTS     = 5;
  localparam int IDLE_NONE        = 0;
  localparam int IDLE_SENDER      = 1;
  localparam int IDLE_RECEIVER    = 2;
  localparam int IDLE_BOTH        = 3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [5:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [63:0] m_tdata;
  logic        cfg_wen = 1'b0;
  logic [9:0]  cfg_wdata = '0;

  int mismatches;
  int outstanding;
  int ticks_seen;
  int expiry_ticks;
  int idle_phase = IDLE_NONE;
  int items_sent = 0;
  int stuck_cycles = 0;

  always #6 clk = ~clk;

  tick_timeslice_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  tts_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .ticks_seen   (ticks_seen),
    .expiry_ticks (expiry_ticks)
  );

  always @(posedge clk) begin
    if (idle_phase == IDLE_RECEIVER) begin
      m_tready <= ($urandom_range(0, 99) >= 83);
    end else if (idle_phase == IDLE_BOTH) begin
      m_tready <= ($urandom_range(0, 99) >= 24);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles + 1 >= WATCHDOG_CYCLES) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_CYCLES);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic bit sender_gap();
    if (idle_phase == IDLE_SENDER) return $urandom_range(0, 99) < 83;
    if (idle_phase == IDLE_BOTH) return $urandom_range(0, 99) < 24;
    return 1'b0;
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [3:0] sel,
                           input logic [15:0] load, input logic [2:0] mode, input logic fm);
    while (sender_gap()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, fm, mode, load};
    s_tuser  <= {sel, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random();
    int roll;
    logic [1:0]  act;
    logic [3:0]  sel;
    logic [15:0] load;
    logic [2:0]  mode;
    roll = $urandom_range(0, 99);
    if (roll < 62) act = ACT_TICK;
    else if (roll < 80) act = ACT_LOAD;
    else if (roll < 96) act = ACT_READ;
    else act = ACT_NONE;
    sel = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 10))
                                       : 4'($urandom_range(11, 15));
    roll = $urandom_range(0, 9);
    if (act != ACT_LOAD || roll > 7) load = 16'($urandom);
    else if (roll < 6) load = 16'($urandom_range(1, 4));
    else if (roll == 6) load = 16'h0000;
    else load = 16'hFFFF;
    mode = ($urandom_range(0, 99) < 70) ? 3'($urandom_range(0, 1))
                                        : 3'($urandom_range(2, 7));
    send_item(act, sel, load, mode, 1'($urandom_range(0, 1)));
  endtask

  // sender holds off until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ptt_period(input logic [9:0] secs);
    cfg_wen   <= 1'b1;
    cfg_wdata <= secs;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  initial begin : stimulus
    logic [9:0] ptt_settings [NUM_SEGMENTS];
    ptt_settings = '{10'd2, 10'd655, 10'd1, 10'd0, 10'd3};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_ptt_period(10'd1);

    send_item(ACT_READ, CD_VFO_SAVE, 16'h0000, MODE_FOREGROUND, 1'b0);
    send_item(ACT_NONE, 4'd15, 16'hFFFF, 3'd7, 1'b1);
    send_item(ACT_LOAD, CD_VFO_SAVE, 16'hFFFF, MODE_FOREGROUND, 1'b0);
    send_item(ACT_READ, CD_VFO_SAVE, 16'h0000, MODE_FOREGROUND, 1'b0);
    send_item(ACT_LOAD, 4'd15, 16'h5A5A, MODE_FOREGROUND, 1'b0);
    send_item(ACT_READ, 4'd15, 16'h0000, MODE_FOREGROUND, 1'b0);
    send_item(ACT_LOAD, CD_VFO_SAVE, 16'h0001, MODE_FOREGROUND, 1'b0);
    send_item(ACT_LOAD, CD_BATT_SAVE, 16'h0001, MODE_FOREGROUND, 1'b0);
    send_item(ACT_LOAD, CD_POWER_SAVE, 16'h0001, MODE_FOREGROUND, 1'b0);
    send_item(ACT_LOAD, CD_TAIL_NOTE, 16'h0001, MODE_FOREGROUND, 1'b0);
    send_item(ACT_LOAD, CD_FM_PLAY, 16'h0001, MODE_FOREGROUND, 1'b0);
    send_item(ACT_LOAD, CD_TX_TIMEOUT, 16'h0001, MODE_FOREGROUND, 1'b0);
    // fm play held by transmit mode, battery save held outside foreground
    send_item(ACT_TICK, 4'd0, 16'h0000, MODE_TRANSMIT, 1'b1);
    send_item(ACT_TICK, 4'd0, 16'h0000, MODE_FOREGROUND, 1'b0);
    send_item(ACT_TICK, 4'd0, 16'h0000, MODE_POWER_SAVE, 1'b1);
    send_item(ACT_LOAD, CD_FM_PLAY, 16'h0001, MODE_FOREGROUND, 1'b0);
    send_item(ACT_TICK, 4'd0, 16'h0000, 3'd7, 1'b1);
    send_item(ACT_LOAD, CD_BOOT, 16'h0000, MODE_FOREGROUND, 1'b0);
    send_item(ACT_READ, CD_BOOT, 16'h0000, MODE_FOREGROUND, 1'b0);
    send_item(ACT_READ, CD_TX_TIMEOUT, 16'h0000, MODE_FOREGROUND, 1'b0);
    drain();

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      idle_phase = seg % 4;
      set_ptt_period(ptt_settings[seg]);
      for (int i = 0; i < SEGMENT_ITEMS; i++) send_random();
      drain();
    end
    idle_phase = IDLE_NONE;
    repeat (8) @(posedge clk);

    $display("covered %0d transactions: %0d ticks, %0d ticks with a countdown expiry,",
             items_sent, ticks_seen, expiry_ticks);
    $display("auto PTT periods from off to 655 s, under sender and receiver stalls");
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_timebase.sv
rtl/tts_countdowns.sv
rtl/tick_timeslice_scheduler.sv
verif/tts_result_checker.sv
verif/tb_top.sv
